[sv/bmh_pkg.sv]
// shared constants and types for the binary min-heap engine
package bmh_pkg;

   localparam int DefaultCapacity  = 1024;
   localparam int DefaultDataWidth = 32;
   localparam int ReqWidth         = 32;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_BUILD = 2'd1;
   localparam logic [1:0] OP_POP   = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_POPPED = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   typedef struct packed {
      logic take;
      logic right;
   } pick_type;

endpackage

[sv/bmh_child_sel.sv]
// picks the child a node trades places with during a sift-down step
module bmh_child_sel #(
   parameter int DATA_WIDTH = bmh_pkg::DefaultDataWidth
) (
   input  logic signed [DATA_WIDTH-1:0] node_value,
   input  logic signed [DATA_WIDTH-1:0] left_value,
   input  logic signed [DATA_WIDTH-1:0] right_value,
   input  logic                         right_ok,
   output bmh_pkg::pick_type            pick
);

   logic                         use_right;
   logic signed [DATA_WIDTH-1:0] cand;

   // on a tie between the children the left one wins
   assign use_right  = right_ok && (right_value < left_value);
   assign cand       = use_right ? right_value : left_value;
   assign pick.take  = cand < node_value;
   assign pick.right = use_right;

endmodule

[sv/binary_min_heap_engine_core.sv]
// binary min-heap engine: store memory, element count and sift-down sequencer
//
// A request is taken when start is high and busy is low. req_operation picks
// load (append req_value), build (heap order over all stored entries) or pop
// (remove the smallest entry). Every request gives exactly one response: a
// one-cycle rsp_valid strobe with rsp_status and rsp_popped_value, which the
// receiver must take in that cycle.
// Load, empty pop, short build and the unused code answer in the cycle after
// they are taken. A pop reads the root and the last entry, moves the last
// entry to the root and sinks it level by level; at 1024 entries it sinks at
// most 9 levels. A build walks the internal nodes from the last one back to
// the root, reads each one and sinks it the same way. Each level of a sink
// is one registered read of both children, then a compare and one write
// back.
// The response of one request shows while the next request may already be
// taken. Reset empties the heap by clearing the count; the memory itself is
// not cleared and needs no sweep.
module binary_min_heap_engine_core #(
   parameter int CAPACITY   = bmh_pkg::DefaultCapacity,
   parameter int DATA_WIDTH = bmh_pkg::DefaultDataWidth
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_operation,
   input  logic signed [bmh_pkg::ReqWidth-1:0]  req_value,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_status,
   output logic signed [bmh_pkg::ReqWidth-1:0]  rsp_popped_value
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = AW + 2;

   typedef enum logic [6:0] {
      S_IDLE       = 7'b0000001,
      S_POP_RD     = 7'b0000010,
      S_POP_TAKE   = 7'b0000100,
      S_BUILD_RD   = 7'b0001000,
      S_BUILD_TAKE = 7'b0010000,
      S_SIFT_RD    = 7'b0100000,
      S_SIFT_CMP   = 7'b1000000
   } state_type;

   logic signed [DATA_WIDTH-1:0] mem [CAPACITY];

   state_type                    state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [AW-1:0]                node_ff, node_in;
   logic [AW-1:0]                build_node_ff, build_node_in;
   logic signed [DATA_WIDTH-1:0] val_ff, val_in;
   logic signed [DATA_WIDTH-1:0] top_ff, top_in;
   logic                         is_build_ff, is_build_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   rsp_status_ff, rsp_status_in;
   logic signed [bmh_pkg::ReqWidth-1:0] rsp_popped_ff, rsp_popped_in;
   logic signed [DATA_WIDTH-1:0] rdata_a_ff, rdata_b_ff;

   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic signed [DATA_WIDTH-1:0] wr_data;
   logic [AW-1:0]                rd_addr_a, rd_addr_b;

   logic                         accept;
   logic [XW-1:0]                left_idx, right_idx, size_x;
   logic [CW-1:0]                build_first;
   logic [CW-1:0]                last_idx;
   logic                         right_ok;
   bmh_pkg::pick_type            pick;

   assign accept      = start && (state_ff == S_IDLE);
   assign size_x      = XW'(count_ff);
   assign left_idx    = (XW'(node_ff) << 1) + XW'(1);
   assign right_idx   = (XW'(node_ff) << 1) + XW'(2);
   assign right_ok    = right_idx < size_x;
   assign build_first = (count_ff - CW'(2)) >> 1;
   assign last_idx    = count_ff - CW'(1);

   bmh_child_sel #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_child_sel (
      .node_value  (val_ff),
      .left_value  (rdata_a_ff),
      .right_value (rdata_b_ff),
      .right_ok    (right_ok),
      .pick        (pick)
   );

   always_comb begin
      logic finish;
      finish        = 1'b0;
      state_in      = state_ff;
      count_in      = count_ff;
      node_in       = node_ff;
      build_node_in = build_node_ff;
      val_in        = val_ff;
      top_in        = top_ff;
      is_build_in   = is_build_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_popped_in = rsp_popped_ff;
      wr_en         = 1'b0;
      wr_addr       = node_ff;
      wr_data       = val_ff;
      rd_addr_a     = node_ff;
      rd_addr_b     = node_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_popped_in = '0;
               rsp_status_in = bmh_pkg::ST_OK;
               case (req_operation)
                  bmh_pkg::OP_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff < CW'(CAPACITY)) begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = DATA_WIDTH'(req_value);
                        count_in = count_ff + CW'(1);
                     end else begin
                        rsp_status_in = bmh_pkg::ST_FULL;
                     end
                  end
                  bmh_pkg::OP_BUILD: begin
                     if (count_ff >= CW'(2)) begin
                        is_build_in   = 1'b1;
                        build_node_in = build_first[AW-1:0];
                        state_in      = S_BUILD_RD;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  bmh_pkg::OP_POP: begin
                     if (count_ff != '0) begin
                        is_build_in = 1'b0;
                        state_in    = S_POP_RD;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = bmh_pkg::ST_EMPTY;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_POP_RD: begin
            rd_addr_a = '0;
            rd_addr_b = last_idx[AW-1:0];
            state_in  = S_POP_TAKE;
         end
         S_POP_TAKE: begin
            // the last entry goes to the root and sinks from there
            top_in   = rdata_a_ff;
            val_in   = rdata_b_ff;
            count_in = count_ff - CW'(1);
            node_in  = '0;
            state_in = S_SIFT_RD;
         end
         S_BUILD_RD: begin
            rd_addr_a = build_node_ff;
            state_in  = S_BUILD_TAKE;
         end
         S_BUILD_TAKE: begin
            val_in   = rdata_a_ff;
            node_in  = build_node_ff;
            state_in = S_SIFT_RD;
         end
         S_SIFT_RD: begin
            if (left_idx >= size_x) begin
               wr_en  = 1'b1;
               finish = 1'b1;
            end else begin
               rd_addr_a = left_idx[AW-1:0];
               rd_addr_b = right_idx[AW-1:0];
               state_in  = S_SIFT_CMP;
            end
         end
         S_SIFT_CMP: begin
            wr_en = 1'b1;
            if (pick.take) begin
               // child moves up, the sinking value stays in val_ff
               wr_data  = pick.right ? rdata_b_ff : rdata_a_ff;
               node_in  = pick.right ? right_idx[AW-1:0] : left_idx[AW-1:0];
               state_in = S_SIFT_RD;
            end else begin
               finish = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (finish) begin
         if (is_build_ff && (build_node_ff != '0)) begin
            build_node_in = build_node_ff - AW'(1);
            state_in      = S_BUILD_RD;
         end else begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (is_build_ff) begin
               rsp_status_in = bmh_pkg::ST_OK;
               rsp_popped_in = '0;
            end else begin
               rsp_status_in = bmh_pkg::ST_POPPED;
               rsp_popped_in = bmh_pkg::ReqWidth'(top_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_a_ff <= mem[rd_addr_a];
      rdata_b_ff <= mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         is_build_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         is_build_ff  <= is_build_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff       <= node_in;
      build_node_ff <= build_node_in;
      val_ff        <= val_in;
      top_ff        <= top_in;
      rsp_status_ff <= rsp_status_in;
      rsp_popped_ff <= rsp_popped_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_popped_value = rsp_popped_ff;

endmodule

[sv/bmh_checker.sv]
// port-level checks for the min-heap engine, bound to the top level
module bmh_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic [1:0]                          req_operation,
   input logic                                rsp_valid,
   input logic [1:0]                          rsp_status,
   input logic signed [bmh_pkg::ReqWidth-1:0] rsp_popped_value
);

   logic accept;
   assign accept = start && !busy;

   // a response only follows a request taken or work in flight
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept) || $past(busy))
      else $error("response without a request");

   a_busy_from_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a request");

   a_popped_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != bmh_pkg::ST_POPPED) |-> rsp_popped_value == '0)
      else $error("popped value not zero");

   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == bmh_pkg::OP_LOAD) |=>
         (rsp_valid && !busy &&
          (rsp_status == bmh_pkg::ST_OK || rsp_status == bmh_pkg::ST_FULL)))
      else $error("load response missing");

   a_pop_path: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == bmh_pkg::OP_POP) |=>
         (busy || (rsp_valid && rsp_status == bmh_pkg::ST_EMPTY)))
      else $error("pop neither started nor reported empty");

endmodule

bind binary_min_heap_engine_core bmh_checker u_bmh_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_operation    (req_operation),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_popped_value (rsp_popped_value)
);

[dv/tb.sv]
// self-checking testbench for the binary min-heap engine core
module tb;

   localparam int Capacity = bmh_pkg::DefaultCapacity;
   localparam logic [1:0] OpUnused = 2'd3;
   localparam int ItemTarget = 1150;
   localparam int FillAfter = 90;
   localparam int QuietLimit = 20000;
   localparam int SettleCycles = 60;

   // software copy of the heap store and the responses it owes
   class heap_scoreboard;
      typedef struct {
         logic [1:0]         status;
         logic signed [31:0] popped;
      } outcome_type;

      logic signed [31:0] slots [Capacity];
      int unsigned        count;
      outcome_type        owed [$];
      int unsigned        errors;

      function new();
         count = 0;
         errors = 0;
      endfunction

      function int unsigned stored();
         return count;
      endfunction

      function int unsigned pending();
         return owed.size();
      endfunction

      // swap down with the smaller child, left child wins a tie
      function void sink(int unsigned node, int unsigned size);
         int unsigned left;
         int unsigned right;
         int unsigned least;
         logic signed [31:0] held;
         bit done;
         done = 0;
         while (!done) begin
            left = 2 * node + 1;
            right = 2 * node + 2;
            least = node;
            if (left < size && slots[left] < slots[least]) least = left;
            if (right < size && slots[right] < slots[least]) least = right;
            if (least == node) begin
               done = 1;
            end else begin
               held = slots[node];
               slots[node] = slots[least];
               slots[least] = held;
               node = least;
            end
         end
      endfunction

      function void note_request(logic [1:0] op, logic signed [31:0] val);
         outcome_type o;
         int i;
         o.status = bmh_pkg::ST_OK;
         o.popped = '0;
         case (op)
            bmh_pkg::OP_LOAD: begin
               if (count < Capacity) begin
                  slots[count] = val;
                  count++;
               end else begin
                  o.status = bmh_pkg::ST_FULL;
               end
            end
            bmh_pkg::OP_BUILD: begin
               if (count >= 2) begin
                  for (i = (count - 2) / 2; i >= 0; i--) sink(i, count);
               end
            end
            bmh_pkg::OP_POP: begin
               if (count == 0) begin
                  o.status = bmh_pkg::ST_EMPTY;
               end else begin
                  o.status = bmh_pkg::ST_POPPED;
                  o.popped = slots[0];
                  slots[0] = slots[count - 1];
                  count--;
                  sink(0, count);
               end
            end
            default: ;
         endcase
         owed.push_back(o);
      endfunction

      function void check_response(logic [1:0] status, logic signed [31:0] popped);
         outcome_type o;
         if (owed.size() == 0) begin
            $display("%0t unexpected response: status %0d value %0d", $time, status, popped);
            errors++;
            return;
         end
         o = owed.pop_front();
         if (status !== o.status) begin
            $display("%0t status mismatch: expected %0d actual %0d", $time, o.status, status);
            errors++;
         end
         if (popped !== o.popped) begin
            $display("%0t popped value mismatch: expected %0d actual %0d",
                     $time, o.popped, popped);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_operation = bmh_pkg::OP_LOAD;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_popped_value;

   heap_scoreboard sb;
   int  sent = 0;
   bit  idle_on = 1;
   bit  filled = 0;
   int  quiet = 0;

   binary_min_heap_engine_core #(
      .CAPACITY(Capacity),
      .DATA_WIDTH(bmh_pkg::DefaultDataWidth)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_popped_value(rsp_popped_value)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) sb.check_response(rsp_status, rsp_popped_value);
   end

   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1) begin
         quiet <= 0;
      end else if (quiet >= QuietLimit) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 16) - 8;
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(input logic [1:0] op, input logic signed [31:0] val);
      if (idle_on && $urandom_range(0, 99) < 8) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_value <= val;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(op, val);
      sent++;
   endtask

   // hold off until every owed response is back
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic run_sequence();
      int n;
      int m;
      if ($urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 8);
         repeat (n) send_request(2'($urandom_range(0, 3)), pick_value());
      end else begin
         n = $urandom_range(1, 24);
         repeat (n) send_request(bmh_pkg::OP_LOAD, pick_value());
         if ($urandom_range(0, 4) != 0) send_request(bmh_pkg::OP_BUILD, $urandom);
         m = $urandom_range(1, n + 2);
         repeat (m) send_request(bmh_pkg::OP_POP, $urandom);
      end
   endtask

   // back-to-back loads up to capacity, a few dropped, then a full-size build and pops
   task automatic fill_store();
      idle_on = 0;
      while (sb.stored() < Capacity) send_request(bmh_pkg::OP_LOAD, pick_value());
      repeat (3) send_request(bmh_pkg::OP_LOAD, pick_value());
      send_request(bmh_pkg::OP_BUILD, $urandom);
      repeat (30) send_request(bmh_pkg::OP_POP, $urandom);
      idle_on = 1;
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty heap, single entry, unused code
      send_request(bmh_pkg::OP_POP, $urandom);
      send_request(bmh_pkg::OP_BUILD, $urandom);
      send_request(bmh_pkg::OP_LOAD, 32'sd7);
      send_request(bmh_pkg::OP_BUILD, $urandom);
      send_request(bmh_pkg::OP_POP, $urandom);
      send_request(bmh_pkg::OP_POP, $urandom);
      send_request(OpUnused, $urandom);
      // extremes and a tie
      send_request(bmh_pkg::OP_LOAD, 32'h7fffffff);
      send_request(bmh_pkg::OP_LOAD, 32'h80000000);
      send_request(bmh_pkg::OP_LOAD, 32'sd0);
      send_request(bmh_pkg::OP_LOAD, -32'sd1);
      send_request(bmh_pkg::OP_LOAD, 32'sd1);
      send_request(bmh_pkg::OP_LOAD, 32'sd3);
      send_request(bmh_pkg::OP_LOAD, 32'sd3);
      send_request(bmh_pkg::OP_POP, $urandom);
      send_request(bmh_pkg::OP_BUILD, $urandom);
      repeat (7) send_request(bmh_pkg::OP_POP, $urandom);
      wait_drained();

      while (sent < ItemTarget) begin
         if (!filled && sent >= FillAfter) begin
            fill_store();
            filled = 1;
         end else begin
            run_sequence();
         end
         if ($urandom_range(0, 3) == 0) wait_drained();
      end

      wait_drained();
      repeat (SettleCycles) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

[filelist.f]
sv/bmh_pkg.sv
sv/bmh_child_sel.sv
sv/binary_min_heap_engine_core.sv
sv/bmh_checker.sv
dv/tb.sv
